### rtl/dvm_pkg.sv
package dvm_pkg;

  // field widths
  localparam int DepthW   = 16;
  localparam int IdxW     = 12;
  localparam int CenterW  = 16;
  localparam int InvW     = 24;
  localparam int CoordW   = 33;
  localparam int ZW       = 29;
  localparam int CfgDataW = 24;
  localparam int CfgIdxW  = 2;

  // pipeline depth, output register included
  localparam int NumStages = 7;

  // internal widths of the axis datapath
  localparam int OffW    = 17;  // signed Q12.4 offset
  localparam int MagW    = 16;  // offset magnitude
  localparam int Prod1W  = 32;  // offset * depth
  localparam int Prod2W  = 56;  // offset * depth * inverse focal length
  localparam int QuotTW  = 40;  // product / 2^16, rounding bias added
  localparam int EstW    = 63;  // reciprocal estimate product
  localparam int QuotW   = 31;  // metres in Q19.12, magnitude
  localparam int RemW    = 11;  // remainder of the divide by 1000

  // rounding bias in units of 2^16: half of 65536000
  localparam logic [QuotTW-1:0] RoundBias  = 40'd500;
  // floor(0.512 * 2^32), applied to the quotient input shifted right by 9
  localparam logic [31:0]       RecipMilli = 32'd2199023255;
  localparam logic [9:0]        MilliDiv   = 10'd1000;

  // depth path: z = (depth * 4096 + 500) / 1000
  localparam int ZNumW  = 28;
  localparam int ZProdW = 57;
  localparam int ZQW    = 19;
  localparam int ZShift = 38;
  localparam logic [ZNumW-1:0] ZBias  = 28'd500;
  // ceil(2^38 / 1000), exact over the whole numerator range
  localparam logic [28:0]      ZRecip = 29'd274877907;

  // 100000.0 in Q20.12
  localparam logic [ZW-1:0] Sentinel = 29'd409600000;

  // register reset values
  localparam logic [InvW-1:0]    InvFocalXRst = 24'd31957;
  localparam logic [InvW-1:0]    InvFocalYRst = 24'd31957;
  localparam logic [CenterW-1:0] CenterXRst   = 16'd5112;
  localparam logic [CenterW-1:0] CenterYRst   = 16'd3832;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInvFocalX = 2'd0,
    CfgInvFocalY = 2'd1,
    CfgCenterX   = 2'd2,
    CfgCenterY   = 2'd3
  } cfg_reg_e;

  // one axis result before the sign is applied
  typedef struct packed {
    logic             neg;
    logic [QuotW-1:0] mag;
  } axis_res_t;

endpackage

### rtl/dvm_stream_if.sv
// depth pixel channel
interface dvm_pix_if
  import dvm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DepthW-1:0] depth;
  logic [IdxW-1:0]   column;
  logic [IdxW-1:0]   row;

  modport source (output valid, depth, column, row, input ready);
  modport sink   (input valid, depth, column, row, output ready);
endinterface

// vertex channel
interface dvm_vtx_if
  import dvm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] x;
  logic signed [CoordW-1:0] y;
  logic        [ZW-1:0]     z;

  modport source (output valid, x, y, z, input ready);
  modport sink   (input valid, x, y, z, output ready);
endinterface

### rtl/depth_to_vertex_map.sv
// Throughput: one item per cycle while the output is not stalled; each stage holds one multiplier
// of at most 32 x 32 bits or one wide add, and the chain of 7 register stages, the first loaded
// at the accepting edge, sets the latency.
// A stall on the output halts only the stages that are full; bubbles still close up.
// Reset clears every stage valid bit and loads the register defaults; data needs no reset.
module depth_to_vertex_map
  import dvm_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dvm_pix_if.sink             in_i,
  dvm_vtx_if.source           out_o
);

  localparam logic [IdxW-1:0] ColLimit =
    (MAX_WIDTH > (1 << IdxW)) ? {IdxW{1'b1}} : IdxW'(MAX_WIDTH - 1);
  localparam logic [IdxW-1:0] RowLimit =
    (MAX_HEIGHT > (1 << IdxW)) ? {IdxW{1'b1}} : IdxW'(MAX_HEIGHT - 1);
  localparam logic [ZW-1:0] ZMax = 29'd268431;

  logic [InvW-1:0]      inv_focal_x_q, inv_focal_y_q;
  logic [CenterW-1:0]   center_x_q, center_y_q;
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  logic [IdxW-1:0]      col_c, row_c;
  axis_res_t            xres, yres;
  logic [ZNumW-1:0]     znum_d;
  logic [ZNumW-1:0]     znum_q;
  logic [ZProdW-1:0]    zprod;
  logic [ZQW-1:0]       z_q [1:NumStages-2];
  logic                 zero_q [0:NumStages-2];
  logic [CoordW-1:0]    x_d, y_d, x_q, y_q;
  logic [ZW-1:0]        z_d, zo_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_focal_x_q <= InvFocalXRst;
      inv_focal_y_q <= InvFocalYRst;
      center_x_q    <= CenterXRst;
      center_y_q    <= CenterYRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgInvFocalX: inv_focal_x_q <= cfg_data_i;
        CfgInvFocalY: inv_focal_y_q <= cfg_data_i;
        CfgCenterX:   center_x_q    <= cfg_data_i[CenterW-1:0];
        CfgCenterY:   center_y_q    <= cfg_data_i[CenterW-1:0];
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the one after it moves
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = v_q[NumStages-1];

  // valid bits travel with the items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // clamp pixel indices to the frame
  assign col_c = (in_i.column > ColLimit) ? ColLimit : in_i.column;
  assign row_c = (in_i.row > RowLimit) ? RowLimit : in_i.row;

  dvm_axis u_axis_x (
    .clk_i       (clk_i),
    .en_i        (en[NumStages-2:0]),
    .index_i     (col_c),
    .center_i    (center_x_q),
    .inv_focal_i (inv_focal_x_q),
    .depth_i     (in_i.depth),
    .res_o       (xres)
  );

  dvm_axis u_axis_y (
    .clk_i       (clk_i),
    .en_i        (en[NumStages-2:0]),
    .index_i     (row_c),
    .center_i    (center_y_q),
    .inv_focal_i (inv_focal_y_q),
    .depth_i     (in_i.depth),
    .res_o       (yres)
  );

  // depth path: stage 1 numerator, stage 2 divide by 1000 through the reciprocal
  assign znum_d = {in_i.depth, 12'h000} + ZBias;
  assign zprod  = ZProdW'(znum_q) * ZProdW'(ZRecip);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      znum_q    <= znum_d;
      zero_q[0] <= (in_i.depth == '0);
    end
    if (en[1]) begin
      z_q[1]    <= zprod[ZProdW-1:ZShift];
      zero_q[1] <= zero_q[0];
    end
    for (int k = 2; k < NumStages - 1; k++) begin
      if (en[k]) begin
        z_q[k]    <= z_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // output stage: apply sign, or the sentinel for a missing depth
  always_comb begin
    x_d = xres.neg ? (CoordW'(0) - CoordW'(xres.mag)) : CoordW'(xres.mag);
    y_d = yres.neg ? (CoordW'(0) - CoordW'(yres.mag)) : CoordW'(yres.mag);
    z_d = ZW'(z_q[NumStages-2]);
    if (zero_q[NumStages-2]) begin
      x_d = CoordW'(Sentinel);
      y_d = CoordW'(Sentinel);
      z_d = Sentinel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      x_q  <= x_d;
      y_q  <= y_d;
      zo_q <= z_d;
    end
  end

  assign out_o.x = $signed(x_q);
  assign out_o.y = $signed(y_q);
  assign out_o.z = zo_q;

  // a sentinel depth only comes from a missing sample, so every axis carries it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.z == Sentinel) |->
      (out_o.x == $signed(CoordW'(Sentinel))) && (out_o.y == $signed(CoordW'(Sentinel))))
    else $error("sentinel not on all axes");

  // a measured depth stays within 65.535 m
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.z != Sentinel) |-> (out_o.z <= ZMax))
    else $error("depth out of range");

  // a measured point fits in 32 signed bits on both lateral axes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.z != Sentinel) |->
      (out_o.x[CoordW-1] == out_o.x[CoordW-2]) && (out_o.y[CoordW-1] == out_o.y[CoordW-2]))
    else $error("lateral coordinate beyond datapath range");

  // with every stage full and the output stalled, no item may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_o.ready |-> !in_i.ready)
    else $error("item accepted into a full pipeline");

endmodule

### rtl/dvm_axis.sv
module dvm_axis
  import dvm_pkg::*;
(
  input  logic                 clk_i,
  input  logic [NumStages-2:0] en_i,
  input  logic [IdxW-1:0]      index_i,
  input  logic [CenterW-1:0]   center_i,
  input  logic [InvW-1:0]      inv_focal_i,
  input  logic [DepthW-1:0]    depth_i,
  output axis_res_t            res_o
);

  logic [OffW-1:0]   off;
  logic [OffW-1:0]   off_abs;
  logic [MagW-1:0]   mag1_d, mag1_q;
  logic [DepthW-1:0] dep1_q;
  logic [Prod1W-1:0] p1_q;
  logic [Prod2W-1:0] p2_q;
  logic [QuotTW-1:0] t_q;
  logic [EstW-1:0]   est_prod;
  logic [QuotW-1:0]  qest_q;
  logic [RemW-1:0]   tlo_q;
  logic [20:0]       back_full;
  logic [RemW-1:0]   rem;
  logic              corr;
  logic [QuotW-1:0]  q6_d;
  logic [4:0]        neg_q;
  axis_res_t         res_q;

  // stage 1: offset from the principal point in Q12.4, split into sign and magnitude
  always_comb begin
    off     = {1'b0, index_i, 4'b0000} - {1'b0, center_i};
    off_abs = off[OffW-1] ? (OffW'(0) - off) : off;
    mag1_d  = off_abs[MagW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag1_q   <= mag1_d;
      dep1_q   <= depth_i;
      neg_q[0] <= off[OffW-1];
    end
  end

  // stage 2: offset times depth
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p1_q     <= mag1_q * dep1_q;
      neg_q[1] <= neg_q[0];
    end
  end

  // stage 3: times inverse focal length
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p2_q     <= Prod2W'(p1_q) * Prod2W'(inv_focal_i);
      neg_q[2] <= neg_q[1];
    end
  end

  // stage 4: drop 16 fraction bits, add half of the divisor
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      t_q      <= p2_q[Prod2W-1:16] + RoundBias;
      neg_q[3] <= neg_q[2];
    end
  end

  // stage 5: quotient estimate by 1000, low by at most one
  assign est_prod = EstW'(t_q[QuotTW-1:9]) * EstW'(RecipMilli);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      qest_q   <= est_prod[EstW-1:32];
      tlo_q    <= t_q[RemW-1:0];
      neg_q[4] <= neg_q[3];
    end
  end

  // stage 6: remainder check and correction; remainder stays below 2000
  always_comb begin
    back_full = qest_q[RemW-1:0] * MilliDiv;
    rem       = tlo_q - back_full[RemW-1:0];
    corr      = (rem >= {1'b0, MilliDiv});
    q6_d      = qest_q + QuotW'(corr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      res_q.mag <= q6_d;
      res_q.neg <= neg_q[4];
    end
  end

  assign res_o = res_q;

endmodule
